### rtl/indexed_insert_remove_list_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the indexed insert/remove list
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef INDEXED_INSERT_REMOVE_LIST_TOP_ASSERT_SVH
`define INDEXED_INSERT_REMOVE_LIST_TOP_ASSERT_SVH

// same-cycle implication
`define IIRL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IIRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/iirl_pkg.sv
// ----------------------------------------------------------------------------
// iirl_pkg
// Shared constants, types and helpers for the indexed insert/remove list.
// ----------------------------------------------------------------------------
`default_nettype none

package iirl_pkg;

  localparam int DEPTH      = 64;
  localparam int ELEM_WIDTH = 32;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  // position port is 7 bits wide; compares run at the wider of the two
  localparam int POS_W = 7;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // read-out tree grouping
  localparam int GRP  = 8;
  localparam int NGRP = (DEPTH + GRP - 1) / GRP;

  typedef logic [ELEM_WIDTH-1:0] elem_t;

  localparam logic [2:0] OP_APPEND  = 3'd0;
  localparam logic [2:0] OP_INSERT  = 3'd1;
  localparam logic [2:0] OP_REPLACE = 3'd2;
  localparam logic [2:0] OP_REMOVE  = 3'd3;
  localparam logic [2:0] OP_GET     = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INS,   // cell ipos takes din, cells above take left neighbour
    CM_REP,   // cell ipos takes din
    CM_REM    // cells at ipos and above take right neighbour
  } cell_mode_t;

  typedef struct packed {
    logic             load;
    cell_mode_t       mode;
    logic [IDX_W-1:0] ipos;
    logic             rd_en;
  } cell_cmd_t;

  function automatic elem_t to_elem(input logic [31:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[ELEM_WIDTH-1:0];
  endfunction

  function automatic logic [31:0] from_elem(input elem_t e);
    logic [63:0] w;
    w = 64'(e);
    return w[31:0];
  endfunction

endpackage

`default_nettype wire

### rtl/iirl_cell.sv
// ----------------------------------------------------------------------------
// iirl_cell
// One list slot: holds an entry, shifts to/from neighbours, offers a read tap.
// ----------------------------------------------------------------------------
`default_nettype none

module iirl_cell
  import iirl_pkg::*;
(
  input  wire logic             clk,
  input  wire cell_cmd_t        cmd,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire elem_t            din,
  input  wire elem_t            left,
  input  wire elem_t            right,
  output elem_t                 entry,
  output elem_t                 tap
);

  logic hit;
  logic above;

  assign hit   = (cell_idx == cmd.ipos);
  assign above = (cell_idx > cmd.ipos);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      case (cmd.mode)
        CM_INS: begin
          if (hit) entry <= din;
          else if (above) entry <= left;
        end
        CM_REP: begin
          if (hit) entry <= din;
        end
        CM_REM: begin
          if (hit || above) entry <= right;
        end
        default: ;
      endcase
      // only the addressed cell drives a non-zero tap
      tap <= (cmd.rd_en && hit) ? entry : '0;
    end
  end

endmodule

`default_nettype wire

### rtl/iirl_rdtree.sv
// ----------------------------------------------------------------------------
// iirl_rdtree
// Registered OR tree that collects the single live read tap of the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

module iirl_rdtree
  import iirl_pkg::*;
(
  input  wire logic  clk,
  input  wire elem_t taps [DEPTH],
  output elem_t      rd
);

  elem_t pad [NGRP*GRP];
  elem_t grp [NGRP];

  for (genvar i = 0; i < NGRP*GRP; i++) begin : g_pad
    if (i < DEPTH) begin : g_tap
      assign pad[i] = taps[i];
    end else begin : g_zero
      assign pad[i] = '0;
    end
  end

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    elem_t acc;
    always_comb begin
      acc = '0;
      for (int k = 0; k < GRP; k++) acc = acc | pad[g*GRP + k];
    end
    always_ff @(posedge clk) begin
      grp[g] <= acc;
    end
  end

  always_comb begin
    rd = '0;
    for (int g = 0; g < NGRP; g++) rd = rd | grp[g];
  end

endmodule

`default_nettype wire

### rtl/indexed_insert_remove_list_top.sv
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_top
// Ordered list with append, insert, replace, remove and get on a cell row.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Every command gives
// one result beat, marked by a one-cycle done pulse; the receiver cannot
// stall it, so capture on done. A new command can be taken in the same cycle
// that done is shown, but not before: busy holds off new commands until then.
// The list itself updates in the accept cycle (all shifting in one step on
// the cell row); a get's entry then passes the registered cell tap and the
// registered OR tree out of the row. Reset empties the list at once.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_insert_remove_list_top_assert.svh"

module indexed_insert_remove_list_top
  import iirl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  opcode,
  input  wire logic [6:0]  position,
  input  wire logic [31:0] value,
  output logic             done,
  output logic [31:0]      read_value,
  output logic [6:0]       entry_count,
  output logic             is_empty,
  output logic [1:0]       status
);

  typedef enum logic [1:0] {S_IDLE, S_RED1, S_RED2} state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [1:0]       st_pend;
  logic [1:0]       st_next;
  logic             acc;
  cell_cmd_t        cmd;
  elem_t            din;
  elem_t            entries [DEPTH];
  elem_t            taps    [DEPTH];
  elem_t            rd;

  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic             full;

  assign busy  = (state != S_IDLE);
  assign acc   = start && !busy;
  assign din   = to_elem(value);
  assign pos_x = CMP_W'(position);
  assign cnt_x = CMP_W'(count);
  assign full  = (cnt_x == CMP_W'(DEPTH));

  always_comb begin
    cmd.load   = acc;
    cmd.mode   = CM_HOLD;
    cmd.ipos   = IDX_W'(pos_x);
    cmd.rd_en  = 1'b0;
    st_next    = ST_DONE;
    count_next = count;
    case (opcode)
      OP_APPEND: begin
        if (full) st_next = ST_FULL;
        else begin
          // append is an insert at the end
          cmd.mode   = CM_INS;
          cmd.ipos   = IDX_W'(cnt_x);
          count_next = CNT_W'(count + 1'b1);
        end
      end
      OP_INSERT: begin
        if (full) st_next = ST_FULL;
        else if (pos_x > cnt_x) st_next = ST_RANGE;
        else begin
          cmd.mode   = CM_INS;
          count_next = CNT_W'(count + 1'b1);
        end
      end
      OP_REPLACE: begin
        if (pos_x >= cnt_x) st_next = ST_RANGE;
        else cmd.mode = CM_REP;
      end
      OP_REMOVE: begin
        if (pos_x >= cnt_x) st_next = ST_RANGE;
        else begin
          cmd.mode   = CM_REM;
          count_next = CNT_W'(count - 1'b1);
        end
      end
      OP_GET: begin
        if (pos_x >= cnt_x) st_next = ST_RANGE;
        else cmd.rd_en = 1'b1;
      end
      default: ;
    endcase
    if (!acc) cmd.mode = CM_HOLD;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    elem_t left_in;
    elem_t right_in;
    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_left
      assign left_in = entries[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_right
      assign right_in = entries[i+1];
    end
    iirl_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .cell_idx (IDX_W'(i)),
      .din      (din),
      .left     (left_in),
      .right    (right_in),
      .entry    (entries[i]),
      .tap      (taps[i])
    );
  end

  iirl_rdtree u_rdtree (
    .clk  (clk),
    .taps (taps),
    .rd   (rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (acc) begin
            count   <= count_next;
            st_pend <= st_next;
            state   <= S_RED1;
          end
        end
        S_RED1: state <= S_RED2;
        S_RED2: begin
          done        <= 1'b1;
          read_value  <= from_elem(rd);
          entry_count <= 7'(count);
          is_empty    <= (count == '0);
          status      <= st_pend;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `IIRL_ASSERT_NEXT(a_acc_busy, acc, busy, "accepted beat did not raise busy")
  `IIRL_ASSERT_NEXT(a_full_hold,
      acc && full && (opcode == OP_APPEND || opcode == OP_INSERT),
      count == $past(count), "count changed on a full list")
  `IIRL_ASSERT_IMPL(a_fail_zero, done && status != ST_DONE, read_value == '0,
      "failed beat returned data")
  `IIRL_ASSERT_IMPL(a_cnt_max, 1'b1, cnt_x <= CMP_W'(DEPTH), "count above depth")

endmodule

`default_nettype wire
